[src/mexp_pkg.sv]
// shared widths and control types for the modular exponentiation block
package mexp_pkg;

	localparam int MOD_WIDTH  = 16;
	localparam int EXP_WIDTH  = 32;
	localparam int BASE_WIDTH = 32;

	localparam int CNT_W     = $clog2(BASE_WIDTH + 1);
	localparam int EXP_CNT_W = $clog2(EXP_WIDTH + 1);

	typedef logic [MOD_WIDTH-1:0] mod_word_t;

	typedef struct packed {
		logic step;
		logic first;
		logic mbit;
	} mul_ctl_t;

endpackage

[src/mexp_mulmod.sv]
// bit-serial interleaved modular multiplier, msb first, one bit per ctl.step cycle
module mexp_mulmod (
	input  logic                 clk,
	input  mexp_pkg::mul_ctl_t   ctl,
	input  mexp_pkg::mod_word_t  a,
	input  mexp_pkg::mod_word_t  m,
	output mexp_pkg::mod_word_t  acc
);
	import mexp_pkg::*;

	mod_word_t            acc_q;
	mod_word_t            prev;
	logic [MOD_WIDTH:0]   dbl;
	logic [MOD_WIDTH:0]   dbl_red;
	logic [MOD_WIDTH:0]   sum;
	logic [MOD_WIDTH:0]   sum_red;
	logic [MOD_WIDTH:0]   m_ext;

	always_comb begin
		m_ext   = {1'b0, m};
		prev    = ctl.first ? '0 : acc_q;
		dbl     = {prev, 1'b0};
		dbl_red = (dbl >= m_ext) ? dbl - m_ext : dbl;
		sum     = dbl_red + (ctl.mbit ? {1'b0, a} : '0);
		sum_red = (sum >= m_ext) ? sum - m_ext : sum;
	end

	// payload only, no reset needed
	always_ff @(posedge clk) begin
		if (ctl.step) begin
			acc_q <= sum_red[MOD_WIDTH-1:0];
		end
	end

	assign acc = acc_q;

endmodule

[src/modular_exponentiation.sv]
// top level: square-and-multiply modular exponentiation over a bit-serial multiplier
//
//   channel  direction  handshake            payload
//   in       input      in_valid / in_ready   base_value, exponent, modulus
//   out      output     out_valid / out_ready residue
//
// the base is first reduced modulo the modulus, then each exponent bit, msb first,
// costs one modular square plus a modular multiply when the bit is set, all on one
// bit-serial multiplier. arst_n clears the control state; the result waits in an
// output register, and a stalled output holds the block in its finish state
// before a new input.
module modular_exponentiation (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_ready,
	input  logic [mexp_pkg::BASE_WIDTH-1:0]   base_value,
	input  logic [31:0]                       exponent,
	input  logic [15:0]                       modulus,
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic [mexp_pkg::MOD_WIDTH-1:0]    residue
);
	import mexp_pkg::*;

	typedef enum logic [2:0] {
		S_IDLE,
		S_REDUCE,
		S_LOAD,
		S_SQUARE,
		S_SQ_DONE,
		S_MULT,
		S_MUL_DONE,
		S_FINISH
	} state_t;

	state_t                 state_q;
	logic [BASE_WIDTH-1:0]  base_sr_q;
	logic [EXP_WIDTH-1:0]   exp_sr_q;
	mod_word_t              mod_q;
	mod_word_t              b_q;
	mod_word_t              acc_q;
	mod_word_t              mul_sr_q;
	logic [CNT_W-1:0]       bit_cnt_q;
	logic [EXP_CNT_W-1:0]   exp_cnt_q;
	logic                   first_q;
	logic                   out_valid_q;
	mod_word_t              residue_q;

	mul_ctl_t               mul_ctl;
	mod_word_t              mul_a;
	mod_word_t              mul_acc;
	mod_word_t              one_mod;

	assign one_mod = {{(MOD_WIDTH-1){1'b0}}, (mod_q != mod_word_t'(1))};

	always_comb begin
		mul_ctl.step  = (state_q == S_REDUCE) || (state_q == S_SQUARE) || (state_q == S_MULT);
		mul_ctl.first = first_q;
		mul_ctl.mbit  = (state_q == S_REDUCE) ? base_sr_q[BASE_WIDTH-1]
		                                      : mul_sr_q[MOD_WIDTH-1];
		mul_a         = (state_q == S_REDUCE) ? one_mod : acc_q;
	end

	mexp_mulmod u_mulmod (
		.clk    (clk),
		.ctl    (mul_ctl),
		.a      (mul_a),
		.m      (mod_q),
		.acc    (mul_acc)
	);

	assign in_ready  = (state_q == S_IDLE);
	assign out_valid = out_valid_q;
	assign residue   = residue_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
			first_q     <= 1'b0;
			bit_cnt_q   <= '0;
			exp_cnt_q   <= '0;
		end else begin
			if (out_valid_q && out_ready && (state_q != S_FINISH)) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						base_sr_q <= base_value;
						exp_sr_q  <= exponent[EXP_WIDTH-1:0];
						mod_q     <= modulus[MOD_WIDTH-1:0];
						bit_cnt_q <= CNT_W'(BASE_WIDTH);
						first_q   <= 1'b1;
						state_q   <= S_REDUCE;
					end
				end
				S_REDUCE: begin
					base_sr_q <= {base_sr_q[BASE_WIDTH-2:0], 1'b0};
					first_q   <= 1'b0;
					bit_cnt_q <= bit_cnt_q - 1'b1;
					if (bit_cnt_q == CNT_W'(1)) begin
						state_q <= S_LOAD;
					end
				end
				S_LOAD: begin
					b_q       <= mul_acc;
					acc_q     <= one_mod;
					mul_sr_q  <= one_mod;
					exp_cnt_q <= EXP_CNT_W'(EXP_WIDTH);
					bit_cnt_q <= CNT_W'(MOD_WIDTH);
					first_q   <= 1'b1;
					state_q   <= S_SQUARE;
				end
				S_SQUARE, S_MULT: begin
					mul_sr_q  <= {mul_sr_q[MOD_WIDTH-2:0], 1'b0};
					first_q   <= 1'b0;
					bit_cnt_q <= bit_cnt_q - 1'b1;
					if (bit_cnt_q == CNT_W'(1)) begin
						state_q <= (state_q == S_SQUARE) ? S_SQ_DONE : S_MUL_DONE;
					end
				end
				S_SQ_DONE, S_MUL_DONE: begin
					acc_q <= mul_acc;
					if (state_q == S_SQ_DONE && exp_sr_q[EXP_WIDTH-1]) begin
						mul_sr_q  <= b_q;
						bit_cnt_q <= CNT_W'(MOD_WIDTH);
						first_q   <= 1'b1;
						state_q   <= S_MULT;
					end else begin
						exp_sr_q  <= {exp_sr_q[EXP_WIDTH-2:0], 1'b0};
						exp_cnt_q <= exp_cnt_q - 1'b1;
						if (exp_cnt_q == EXP_CNT_W'(1)) begin
							state_q <= S_FINISH;
						end else begin
							mul_sr_q  <= mul_acc;
							bit_cnt_q <= CNT_W'(MOD_WIDTH);
							first_q   <= 1'b1;
							state_q   <= S_SQUARE;
						end
					end
				end
				S_FINISH: begin
					if (!out_valid_q || out_ready) begin
						out_valid_q <= 1'b1;
						// zero modulus gives zero
						residue_q   <= (mod_q == '0) ? '0 : acc_q;
						state_q     <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

`ifndef NO_ASSERTIONS
	a_accept_starts: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> (state_q == S_REDUCE))
		else $error("accepted transaction did not start base reduction");

	a_exp_cnt_live: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_SQUARE || state_q == S_MULT) |-> (exp_cnt_q != '0))
		else $error("exponent bit count ran out during a pass");

	a_acc_reduced: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_FINISH) |-> ((mod_q == '0) || (acc_q < mod_q)))
		else $error("final value not reduced below the modulus");

	a_finish_publishes: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_FINISH && !out_valid_q) |=> (out_valid_q && state_q == S_IDLE))
		else $error("finished result not moved to the output register");
`endif

endmodule

[tb/testbench.sv]
// self-checking testbench for the modular exponentiation block
class residue_scoreboard;
	mexp_pkg::mod_word_t expected_q[$];
	int unsigned mismatches;

	function new();
		mismatches = 0;
	endfunction

	static function mexp_pkg::mod_word_t power_mod(logic [31:0] b, logic [31:0] e,
			logic [15:0] m);
		logic [63:0] acc;
		logic [63:0] bb;
		logic [63:0] mm;
		mm = 64'(m[mexp_pkg::MOD_WIDTH-1:0]);
		if (mm == 0) begin
			return '0;
		end
		bb = 64'(b) % mm;
		acc = 64'd1 % mm;
		for (int i = mexp_pkg::EXP_WIDTH - 1; i >= 0; i--) begin
			acc = (acc * acc) % mm;
			if (e[i]) begin
				acc = (acc * bb) % mm;
			end
		end
		return acc[mexp_pkg::MOD_WIDTH-1:0];
	endfunction

	function void note_input(logic [31:0] b, logic [31:0] e, logic [15:0] m);
		expected_q.push_back(power_mod(b, e, m));
	endfunction

	function void check_residue(mexp_pkg::mod_word_t got);
		mexp_pkg::mod_word_t want;
		if (expected_q.size() == 0) begin
			$display("%0t: unexpected residue %0d", $time, got);
			mismatches++;
		end else begin
			want = expected_q.pop_front();
			if (got !== want) begin
				$display("%0t: residue expected %0d actual %0d", $time, want, got);
				mismatches++;
			end
		end
	endfunction

	function int pending();
		return expected_q.size();
	endfunction
endclass

module testbench;
	localparam int RANDOM_ITEMS = 520;
	localparam int STALL_LIMIT  = 25000;
	localparam int HOLD_AT      = 60;
	localparam int HOLD_CYCLES  = 3000;
	localparam int DRAIN_AT     = 300;

	logic                                clk;
	logic                                arst_n;
	logic                                in_valid;
	logic                                in_ready;
	logic [mexp_pkg::BASE_WIDTH-1:0]     base_value;
	logic [31:0]                         exponent;
	logic [15:0]                         modulus;
	logic                                out_valid;
	logic                                out_ready;
	logic [mexp_pkg::MOD_WIDTH-1:0]      residue;

	residue_scoreboard sb = new();
	int unsigned sent_count = 0;
	int unsigned result_count = 0;

	modular_exponentiation u_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.base_value (base_value),
		.exponent   (exponent),
		.modulus    (modulus),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.residue    (residue)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// runs of items with no idling between runs with random idling
	function automatic int idle_cycles(int unsigned n);
		if ((n / 50) % 4 == 1) begin
			return 0;
		end
		return $urandom_range(0, 19);
	endfunction

	task automatic offer(input logic [31:0] b, input logic [31:0] e, input logic [15:0] m);
		int gap;
		gap = idle_cycles(sent_count);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid   <= 1'b1;
		base_value <= b;
		exponent   <= e;
		modulus    <= m;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		sb.note_input(b, e, m);
		sent_count++;
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		do @(posedge clk); while (sb.pending() != 0);
	endtask

	initial begin
		logic [31:0] b;
		logic [31:0] e;
		logic [15:0] m;
		arst_n     <= 1'b0;
		in_valid   <= 1'b0;
		base_value <= '0;
		exponent   <= '0;
		modulus    <= 16'd1;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// zero exponent, modulus of one, zero base, field extremes
		offer(32'd0, 32'd0, 16'd1);
		offer(32'd0, 32'd0, 16'd65535);
		offer(32'hFFFF_FFFF, 32'd0, 16'd1);
		offer(32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'd1);
		offer(32'd5, 32'd1, 16'd1);
		offer(32'd0, 32'd5, 16'd7);
		offer(32'd0, 32'hFFFF_FFFF, 16'd2);
		offer(32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'd65535);
		offer(32'hFFFF_FFFF, 32'd1, 16'd65535);
		offer(32'd12345, 32'd1, 16'd65535);
		offer(32'd2, 32'd10, 16'd1000);
		offer(32'd3, 32'hFFFF_FFFF, 16'd2);
		offer(32'd7, 32'd2, 16'd65535);
		offer(32'd65535, 32'd2, 16'd65535);
		offer(32'd65534, 32'd3, 16'd65535);
		offer(32'h8000_0000, 32'h8000_0000, 16'd65521);
		offer(32'hAAAA_AAAA, 32'h5555_5555, 16'h5555);
		offer(32'h5555_5555, 32'hAAAA_AAAA, 16'hAAAA);
		offer(32'd1, 32'hFFFF_FFFF, 16'h8000);
		offer(32'd2, 32'd16, 16'd65535);
		drain();

		for (int i = 0; i < RANDOM_ITEMS; i++) begin
			b = $urandom;
			e = $urandom;
			m = 16'($urandom_range(1, 65535));
			case ($urandom_range(0, 5))
				0: m = 16'($urandom_range(1, 16));
				1: m = 16'($urandom_range(65000, 65535));
				2: e = $urandom_range(0, 15);
				3: b = $urandom_range(0, 3);
				4: e = e | 32'h8000_0000;
				default: ;
			endcase
			offer(b, e, m);
			if (i == DRAIN_AT) begin
				drain();
			end
		end
		in_valid <= 1'b0;

		while (sb.pending() != 0) @(posedge clk);
		repeat (40) @(posedge clk);
		if (sb.mismatches == 0 && sb.pending() == 0) begin
			$display("testbench passed");
		end else begin
			$display("testbench failed");
		end
		$finish;
	end

	initial begin
		int gap;
		out_ready <= 1'b0;
		forever begin
			gap = idle_cycles(result_count + 25);
			if (gap > 0) begin
				out_ready <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			out_ready <= 1'b1;
			@(posedge clk);
			while (!out_valid) @(posedge clk);
			sb.check_residue(residue);
			result_count++;
			// long hold-off so the block fills up and stalls its input
			if (result_count == HOLD_AT) begin
				out_ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
			end
		end
	end

	initial begin
		int quiet;
		quiet = 0;
		while (quiet < STALL_LIMIT) begin
			@(posedge clk);
			if ((in_valid && in_ready) || (out_valid && out_ready)) begin
				quiet = 0;
			end else begin
				quiet++;
			end
		end
		$display("testbench failed");
		$finish;
	end
endmodule
